// ===== src/tpws_pkg.sv =====
// shared types and constants for the three-phase window statistics block
`default_nettype none

package tpws_pkg;

  // field and accumulator widths
  localparam int unsigned SampleW   = 16;
  localparam int unsigned CountW    = 13;
  localparam int unsigned SumW      = 29;
  localparam int unsigned SqSumW    = 43;
  localparam int unsigned MagW      = 28;
  localparam int unsigned DivW      = 55;
  localparam int unsigned DivCntW   = 6;
  localparam int unsigned NumPhases = 3;

  // window closes at this many samples
  localparam logic [CountW-1:0] MaxWindow = 13'd4096;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegClipLimit = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNominal   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegTolDiv    = 2'd2;

  localparam logic [1:0] PhaseC = 2'd2;

  // input request
  typedef struct packed {
    logic signed [15:0] sample_a;
    logic signed [15:0] sample_b;
    logic signed [15:0] sample_c;
    logic               last_sample;
  } tpws_in_t;

  // one result
  typedef struct packed {
    logic [1:0]         phase_index;
    logic signed [15:0] dc_offset;
    logic [15:0]        rms_level;
    logic [15:0]        peak_to_peak;
    logic [30:0]        variance_value;
    logic [15:0]        std_deviation;
    logic [12:0]        clip_count;
    logic               rms_in_band;
    logic               last_result;
  } tpws_out_t;

  // per-phase window totals
  typedef struct packed {
    logic [SumW-1:0]    sum;
    logic [SqSumW-1:0]  sq_sum;
    logic [15:0]        max_v;
    logic [15:0]        min_v;
    logic [CountW-1:0]  clip;
  } tpws_acc_t;

  // closed window handed from front to back
  typedef struct packed {
    logic [CountW-1:0]               count;
    tpws_acc_t [NumPhases-1:0]       ph;
  } tpws_win_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HALF,
    ST_BAND,
    ST_DC,
    ST_MS,
    ST_RMS,
    ST_SSQ,
    ST_VSUM,
    ST_VAR,
    ST_STD,
    ST_OUT
  } tpws_state_e;

endpackage

`default_nettype wire

// ===== src/tpws_front.sv =====
// front end: per-sample accumulation and window close detection
`default_nettype none

module tpws_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  tpws_pkg::tpws_in_t  in_i,
  input  logic signed [15:0]  clip_limit_i,
  output logic                win_push_o,
  output tpws_pkg::tpws_win_t win_o
);

  logic [tpws_pkg::CountW-1:0] count_q, count_nx;
  tpws_pkg::tpws_acc_t [tpws_pkg::NumPhases-1:0] acc_q, acc_nx;
  logic signed [15:0] smp [tpws_pkg::NumPhases];
  logic [15:0]        mag [tpws_pkg::NumPhases];
  logic [31:0]        msq [tpws_pkg::NumPhases];
  logic               close;

  assign smp[0] = in_i.sample_a;
  assign smp[1] = in_i.sample_b;
  assign smp[2] = in_i.sample_c;

  // one lane per phase
  always_comb begin
    for (int p = 0; p < tpws_pkg::NumPhases; p++) begin
      mag[p] = smp[p][15] ? 16'(16'd0 - smp[p]) : smp[p];
      msq[p] = mag[p] * mag[p];
      acc_nx[p].sum    = acc_q[p].sum + {{(tpws_pkg::SumW-16){smp[p][15]}}, smp[p]};
      acc_nx[p].sq_sum = acc_q[p].sq_sum + tpws_pkg::SqSumW'(msq[p]);
      acc_nx[p].max_v  = (smp[p] > $signed(acc_q[p].max_v)) ? smp[p] : acc_q[p].max_v;
      acc_nx[p].min_v  = (smp[p] < $signed(acc_q[p].min_v)) ? smp[p] : acc_q[p].min_v;
      acc_nx[p].clip   = (smp[p] >= clip_limit_i) ? acc_q[p].clip + 1'b1 : acc_q[p].clip;
    end
  end

  // window close on marker or full length
  assign count_nx   = count_q + 1'b1;
  assign close      = in_i.last_sample || (count_nx == tpws_pkg::MaxWindow);
  assign win_push_o = valid_i && close;
  assign win_o.count = count_nx;
  assign win_o.ph    = acc_nx;

  // accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      acc_q   <= '0;
    end else if (valid_i) begin
      if (close) begin
        count_q <= '0;
        acc_q   <= '0;
      end else begin
        count_q <= count_nx;
        acc_q   <= acc_nx;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tpws_queue.sv =====
// two-entry queue of closed windows between front and back
`default_nettype none

module tpws_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tpws_pkg::tpws_win_t data_i,
  input  logic                pop_i,
  output tpws_pkg::tpws_win_t data_o,
  output logic                full_o,
  output logic                empty_o
);

  tpws_pkg::tpws_win_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// ===== src/tpws_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module tpws_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tpws_pkg::DivW-1:0]    dividend_i,
  input  logic [tpws_pkg::CountW-1:0]  divisor_i,
  output logic                         done_o,
  output logic [tpws_pkg::DivW-1:0]    quotient_o,
  output logic [tpws_pkg::CountW-1:0]  remainder_o
);

  logic [tpws_pkg::DivW-1:0]    dq_q;
  logic [tpws_pkg::CountW-1:0]  rem_q, dvs_q, rem_nx;
  logic [tpws_pkg::CountW:0]    trial;
  logic [tpws_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q, done_q, ge;

  // shift in next dividend bit and try a subtract
  always_comb begin
    trial  = {rem_q, dq_q[tpws_pkg::DivW-1]};
    ge     = trial >= {1'b0, dvs_q};
    rem_nx = ge ? tpws_pkg::CountW'(trial - {1'b0, dvs_q})
                : tpws_pkg::CountW'(trial);
  end

  assign done_o      = done_q;
  assign quotient_o  = dq_q;
  assign remainder_o = rem_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[tpws_pkg::DivW-2:0], ge};
      rem_q <= rem_nx;
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tpws_pkg::DivCntW'(tpws_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/tpws_back.sv =====
// back end: sequencer that turns window totals into three results
`default_nettype none

module tpws_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                win_empty_i,
  input  tpws_pkg::tpws_win_t win_i,
  output logic                win_pop_o,
  input  logic [14:0]         nominal_i,
  input  logic [7:0]          tol_div_i,
  input  logic                out_pop_i,
  output logic                out_valid_o,
  output tpws_pkg::tpws_out_t out_o
);

  tpws_pkg::tpws_state_e state_q, state_d;
  tpws_pkg::tpws_win_t   ent_q;
  tpws_pkg::tpws_acc_t   cur;
  tpws_pkg::tpws_out_t   out_q;
  logic                  out_valid_q, out_wr, can_write;

  logic [1:0]  phase_q;
  logic [15:0] vmax_q, vmin_q, dc_q, rms_q;
  logic [31:0] vmax2_q, vmin2_q;
  logic [30:0] ms_q, var_q;
  logic        ms_exact_q;

  // divider hookup
  logic                        div_start, div_done;
  logic [tpws_pkg::DivW-1:0]   div_dividend, div_quot;
  logic [tpws_pkg::CountW-1:0] div_divisor, div_rem;

  // square root unit
  logic        sq_load;
  logic [30:0] sq_src;
  logic [31:0] sq_val_q;
  logic [15:0] sq_root_q, sq_root_nx;
  logic [16:0] sq_rem_q, sq_rem_nx;
  logic [18:0] sq_sh, sq_trial;
  logic [3:0]  sq_cnt_q;
  logic        sq_ge;

  // derived values
  logic                      sum_neg, tol;
  logic [tpws_pkg::MagW-1:0] sum_mag;
  logic [55:0]               ssq;
  logic [42:0]               vsum;
  logic [31:0]               ms_ext;
  logic [7:0]                tol_eff;

  tpws_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // current phase operands
  always_comb begin
    cur     = ent_q.ph[phase_q];
    sum_neg = cur.sum[tpws_pkg::SumW-1];
    sum_mag = sum_neg ? tpws_pkg::MagW'(tpws_pkg::SumW'(0) - cur.sum)
                      : cur.sum[tpws_pkg::MagW-1:0];
    ssq     = sum_mag * sum_mag;
    vsum    = cur.sq_sum - tpws_pkg::SqSumW'(div_quot)
              - tpws_pkg::SqSumW'(div_rem != '0);
    tol_eff = (tol_div_i == 8'd0) ? 8'd1 : tol_div_i;
    ms_ext  = {1'b0, ms_q};
    tol     = (ms_ext >= vmin2_q) &&
              ((ms_ext < vmax2_q) || ((ms_ext == vmax2_q) && ms_exact_q));
  end

  // root step: two radicand bits per cycle
  always_comb begin
    sq_sh      = {sq_rem_q, sq_val_q[31:30]};
    sq_trial   = {1'b0, sq_root_q, 2'b01};
    sq_ge      = sq_sh >= sq_trial;
    sq_rem_nx  = sq_ge ? 17'(sq_sh - sq_trial) : 17'(sq_sh);
    sq_root_nx = {sq_root_q[14:0], sq_ge};
  end

  assign can_write = !out_valid_q || out_pop_i;

  // sequencer
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = ent_q.count;
    win_pop_o    = 1'b0;
    sq_load      = 1'b0;
    sq_src       = div_quot[30:0];
    out_wr       = 1'b0;
    case (state_q)
      tpws_pkg::ST_IDLE: begin
        if (!win_empty_i) begin
          win_pop_o    = 1'b1;
          div_start    = 1'b1;
          div_dividend = tpws_pkg::DivW'(nominal_i);
          div_divisor  = tpws_pkg::CountW'(tol_eff);
          state_d      = tpws_pkg::ST_HALF;
        end
      end
      tpws_pkg::ST_HALF: begin
        if (div_done) begin
          state_d = tpws_pkg::ST_BAND;
        end
      end
      tpws_pkg::ST_BAND: begin
        div_start    = 1'b1;
        div_dividend = tpws_pkg::DivW'(sum_mag);
        state_d      = tpws_pkg::ST_DC;
      end
      tpws_pkg::ST_DC: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = tpws_pkg::DivW'(cur.sq_sum);
          state_d      = tpws_pkg::ST_MS;
        end
      end
      tpws_pkg::ST_MS: begin
        if (div_done) begin
          sq_load = 1'b1;
          state_d = tpws_pkg::ST_RMS;
        end
      end
      tpws_pkg::ST_RMS: begin
        if (sq_cnt_q == 4'd15) begin
          state_d = tpws_pkg::ST_SSQ;
        end
      end
      tpws_pkg::ST_SSQ: begin
        div_start    = 1'b1;
        div_dividend = tpws_pkg::DivW'(ssq);
        state_d      = tpws_pkg::ST_VSUM;
      end
      tpws_pkg::ST_VSUM: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = tpws_pkg::DivW'(vsum);
          state_d      = tpws_pkg::ST_VAR;
        end
      end
      tpws_pkg::ST_VAR: begin
        if (div_done) begin
          sq_load = 1'b1;
          state_d = tpws_pkg::ST_STD;
        end
      end
      tpws_pkg::ST_STD: begin
        if (sq_cnt_q == 4'd15) begin
          state_d = tpws_pkg::ST_OUT;
        end
      end
      tpws_pkg::ST_OUT: begin
        if (can_write) begin
          out_wr  = 1'b1;
          state_d = (phase_q == tpws_pkg::PhaseC) ? tpws_pkg::ST_IDLE
                                                  : tpws_pkg::ST_BAND;
        end
      end
      default: begin
        state_d = tpws_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tpws_pkg::ST_IDLE;
      phase_q     <= 2'd0;
      sq_cnt_q    <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (win_pop_o) begin
        phase_q <= 2'd0;
      end else if (out_wr) begin
        phase_q <= phase_q + 2'd1;
      end
      if (sq_load) begin
        sq_cnt_q <= 4'd0;
      end else if (state_q == tpws_pkg::ST_RMS || state_q == tpws_pkg::ST_STD) begin
        sq_cnt_q <= sq_cnt_q + 4'd1;
      end
      if (out_wr) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (win_pop_o) begin
      ent_q <= win_i;
    end
    if (state_q == tpws_pkg::ST_HALF && div_done) begin
      vmax_q <= {1'b0, nominal_i} + {1'b0, div_quot[14:0]};
      vmin_q <= {1'b0, nominal_i} - {1'b0, div_quot[14:0]};
    end
    if (state_q == tpws_pkg::ST_BAND) begin
      vmax2_q <= vmax_q * vmax_q;
      vmin2_q <= vmin_q * vmin_q;
    end
    if (state_q == tpws_pkg::ST_DC && div_done) begin
      dc_q <= sum_neg ? 16'(16'd0 - div_quot[15:0]) : div_quot[15:0];
    end
    if (state_q == tpws_pkg::ST_MS && div_done) begin
      ms_q       <= div_quot[30:0];
      ms_exact_q <= (div_rem == '0);
    end
    if (state_q == tpws_pkg::ST_RMS && sq_cnt_q == 4'd15) begin
      rms_q <= sq_root_nx;
    end
    if (state_q == tpws_pkg::ST_VAR && div_done) begin
      var_q <= div_quot[30:0];
    end
    if (sq_load) begin
      sq_val_q  <= {1'b0, sq_src};
      sq_root_q <= '0;
      sq_rem_q  <= '0;
    end else if (state_q == tpws_pkg::ST_RMS || state_q == tpws_pkg::ST_STD) begin
      sq_val_q  <= {sq_val_q[29:0], 2'b00};
      sq_root_q <= sq_root_nx;
      sq_rem_q  <= sq_rem_nx;
    end
    if (out_wr) begin
      out_q.phase_index    <= phase_q;
      out_q.dc_offset      <= dc_q;
      out_q.rms_level      <= rms_q;
      out_q.peak_to_peak   <= cur.max_v - cur.min_v;
      out_q.variance_value <= var_q;
      out_q.std_deviation  <= sq_root_q;
      out_q.clip_count     <= cur.clip;
      out_q.rms_in_band    <= tol;
      out_q.last_result    <= (phase_q == tpws_pkg::PhaseC);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== src/three_phase_window_statistics_top.sv =====
// top level of the three-phase window statistics block
//
//   port group        dir  handshake        payload
//   sample requests   in   push / full      in_data_i   (tpws_in_t)
//   results           out  empty / pop      out_data_o  (tpws_out_t)
//   configuration     in   cfg_we_i         cfg_idx_i, cfg_data_i
//
// The front takes one sample request per cycle while the window queue has room.
// Each closed window keeps the back busy with one band division and, per phase, four
// divisions on the shared one-bit-per-cycle divider, two square roots and the remaining
// sequencer steps; the back holds each result until the previous one has been taken.
// Three results follow per window. Windows shorter than the back's work per window
// fill the two-entry queue and full holds off requests.
// Reset is asynchronous and active low; no clearing pass is needed.
`default_nettype none

module three_phase_window_statistics_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  tpws_pkg::tpws_in_t                 in_data_i,
  output logic                               empty,
  input  logic                               pop,
  output tpws_pkg::tpws_out_t                out_data_o,
  input  logic                               cfg_we_i,
  input  logic [tpws_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [tpws_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic signed [15:0] clip_limit_q;
  logic [14:0]        nominal_q;
  logic [7:0]         tol_div_q;

  logic                q_push, q_pop, q_full, q_empty, accept, out_valid;
  tpws_pkg::tpws_win_t q_wdata, q_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_limit_q <= 16'sd32767;
      nominal_q    <= 15'd0;
      tol_div_q    <= 8'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tpws_pkg::RegClipLimit: clip_limit_q <= cfg_data_i;
        tpws_pkg::RegNominal:   nominal_q    <= cfg_data_i[14:0];
        tpws_pkg::RegTolDiv:    tol_div_q    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  tpws_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .in_i         (in_data_i),
    .clip_limit_i (clip_limit_q),
    .win_push_o   (q_push),
    .win_o        (q_wdata)
  );

  tpws_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  tpws_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .win_empty_i (q_empty),
    .win_i       (q_rdata),
    .win_pop_o   (q_pop),
    .nominal_i   (nominal_q),
    .tol_div_i   (tol_div_q),
    .out_pop_i   (pop && out_valid),
    .out_valid_o (out_valid),
    .out_o       (out_data_o)
  );

`ifndef SYNTH
  // a closed window never lands on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("window pushed into full queue");

  // the back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("window popped from empty queue");

  // last flag marks exactly the phase C result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.last_result == (out_data_o.phase_index == tpws_pkg::PhaseC)))
    else $error("last_result does not match phase_index");

  // roots stay within range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_data_o.rms_level <= 16'd32768 && out_data_o.std_deviation <= 16'd32768))
    else $error("root out of range");
`endif

endmodule

`default_nettype wire

// ===== tb/three_phase_window_statistics_top_tb.sv =====
// self-checking testbench for the three-phase window statistics block
`timescale 1ns / 1ps

module three_phase_window_statistics_top_tb;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          push;
  logic                          full;
  tpws_pkg::tpws_in_t            in_data_i;
  logic                          empty;
  logic                          pop;
  tpws_pkg::tpws_out_t           out_data_o;
  logic                          cfg_we_i;
  logic [tpws_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [tpws_pkg::CfgDataW-1:0] cfg_data_i;

  three_phase_window_statistics_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // settle time, longer than the back end takes for one window
  localparam int unsigned SettleCycles = 1200;

  // predictor copy of configuration and window totals
  longint          clip_level;
  longint unsigned nominal_level;
  longint unsigned tol_div;
  longint unsigned win_count;
  longint          win_sum   [tpws_pkg::NumPhases];
  longint unsigned win_sq    [tpws_pkg::NumPhases];
  longint          win_max   [tpws_pkg::NumPhases];
  longint          win_min   [tpws_pkg::NumPhases];
  longint unsigned win_clip  [tpws_pkg::NumPhases];

  tpws_pkg::tpws_out_t pending_stats[$];
  int        mismatches;
  int        samples_sent;
  int        windows_sent;
  int        results_seen;
  bit        stalls_on;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("%0t timeout", $time);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic void clear_totals();
    win_count = 0;
    for (int p = 0; p < tpws_pkg::NumPhases; p++) begin
      win_sum[p]  = 0;
      win_sq[p]   = 0;
      win_max[p]  = 0;
      win_min[p]  = 0;
      win_clip[p] = 0;
    end
  endfunction

  // accumulate one sample request and queue the window results on close
  function automatic void predict_window_stats(tpws_pkg::tpws_in_t s);
    longint              x;
    longint unsigned     m, d, half, vmax, vmin, sq, sm, var_v;
    longint              dc;
    tpws_pkg::tpws_out_t r;
    for (int p = 0; p < tpws_pkg::NumPhases; p++) begin
      x = (p == 0) ? longint'(s.sample_a) : (p == 1) ? longint'(s.sample_b)
                                                       : longint'(s.sample_c);
      m = (x < 0) ? -x : x;
      win_sum[p] += x;
      win_sq[p]  += m * m;
      if (x > win_max[p]) win_max[p] = x;
      if (x < win_min[p]) win_min[p] = x;
      if (x >= clip_level) win_clip[p]++;
    end
    win_count++;
    if (!s.last_sample && win_count < tpws_pkg::MaxWindow) return;
    d    = (tol_div == 0) ? 1 : tol_div;
    half = nominal_level / d;
    vmax = nominal_level + half;
    vmin = nominal_level - half;
    for (int p = 0; p < tpws_pkg::NumPhases; p++) begin
      sq    = win_sq[p];
      sm    = (win_sum[p] < 0) ? -win_sum[p] : win_sum[p];
      var_v = (win_count * sq - sm * sm) / (win_count * win_count);
      dc    = win_sum[p] / longint'(win_count);
      r.phase_index    = 2'(p);
      r.dc_offset      = 16'(dc);
      r.rms_level      = 16'(floor_sqrt(sq / win_count));
      r.peak_to_peak   = 16'(win_max[p] - win_min[p]);
      r.variance_value = 31'(var_v);
      r.std_deviation  = 16'(floor_sqrt(var_v));
      r.clip_count     = 13'(win_clip[p]);
      r.rms_in_band    = (vmin * vmin * win_count <= sq) && (sq <= vmax * vmax * win_count);
      r.last_result    = (p == tpws_pkg::PhaseC);
      pending_stats.push_back(r);
    end
    windows_sent++;
    clear_totals();
  endfunction

  task automatic check_result(tpws_pkg::tpws_out_t got);
    tpws_pkg::tpws_out_t want;
    results_seen++;
    if (pending_stats.size() == 0) begin
      $display("%0t unexpected result %h", $time, got);
      mismatches++;
    end else begin
      want = pending_stats.pop_front();
      if (got.phase_index !== want.phase_index)
        $display("%0t phase_index exp %0d got %0d", $time, want.phase_index, got.phase_index);
      if (got.dc_offset !== want.dc_offset)
        $display("%0t dc_offset exp %0d got %0d", $time, want.dc_offset, got.dc_offset);
      if (got.rms_level !== want.rms_level)
        $display("%0t rms_level exp %0d got %0d", $time, want.rms_level, got.rms_level);
      if (got.peak_to_peak !== want.peak_to_peak)
        $display("%0t peak_to_peak exp %0d got %0d", $time, want.peak_to_peak,
                 got.peak_to_peak);
      if (got.variance_value !== want.variance_value)
        $display("%0t variance_value exp %0d got %0d", $time, want.variance_value,
                 got.variance_value);
      if (got.std_deviation !== want.std_deviation)
        $display("%0t std_deviation exp %0d got %0d", $time, want.std_deviation,
                 got.std_deviation);
      if (got.clip_count !== want.clip_count)
        $display("%0t clip_count exp %0d got %0d", $time, want.clip_count, got.clip_count);
      if (got.rms_in_band !== want.rms_in_band)
        $display("%0t rms_in_band exp %0d got %0d", $time, want.rms_in_band,
                 got.rms_in_band);
      if (got.last_result !== want.last_result)
        $display("%0t last_result exp %0d got %0d", $time, want.last_result, got.last_result);
      if (got !== want) mismatches++;
    end
  endtask

  // result consumer with random stall bursts
  int pop_hold;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      pop_hold = 0;
    end else begin
      if (pop && !empty) check_result(out_data_o);
      if (pop_hold == 0 && stalls_on && $urandom_range(0, 9) == 0)
        pop_hold = $urandom_range(1, 17);
      if (!stalls_on) pop_hold = 0;
      pop <= (pop_hold == 0);
      if (pop_hold > 0) pop_hold--;
    end
  end

  // drive one sample request and wait for it to be taken
  task automatic send_sample(logic signed [15:0] a, logic signed [15:0] b,
                             logic signed [15:0] c, logic last);
    tpws_pkg::tpws_in_t s;
    int                 gap;
    s.sample_a    = a;
    s.sample_b    = b;
    s.sample_c    = c;
    s.last_sample = last;
    push      <= 1'b1;
    in_data_i <= s;
    do @(posedge clk_i); while (full);
    predict_window_stats(s);
    samples_sent++;
    if (stalls_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // wait for all results, then let the back end finish
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [tpws_pkg::CfgIdxW-1:0] idx,
                           logic [tpws_pkg::CfgDataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      tpws_pkg::RegClipLimit: clip_level    = longint'($signed(value));
      tpws_pkg::RegNominal:   nominal_level = value & 16'h7FFF;
      tpws_pkg::RegTolDiv:    tol_div       = value & 16'h00FF;
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 15)) - 16'sd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // one window of random samples, closed by last_sample
  task automatic send_random_window(int len);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(), rand_sample(), rand_sample(), i == len - 1);
  endtask

  task automatic test_extremes();
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0000, 1'b1);
    send_sample(16'sh8000, 16'sh7FFF, 16'shFFFF, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh0001, 1'b1);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh0005, 1'b1);
    send_sample(-16'sd3, 16'sd3, -16'sd1, 1'b0);
    send_sample(-16'sd4, 16'sd2, -16'sd1, 1'b1);
  endtask

  task automatic test_clip_limits();
    drain();
    write_reg(tpws_pkg::RegClipLimit, 16'h8000);
    send_random_window(3);
    drain();
    write_reg(tpws_pkg::RegClipLimit, 16'h0000);
    send_sample(16'sd0, -16'sd1, 16'sd1, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, -16'sd1, 1'b1);
    drain();
    write_reg(tpws_pkg::RegClipLimit, 16'h7FFF);
  endtask

  task automatic test_tolerance();
    drain();
    write_reg(tpws_pkg::RegNominal, 16'd1000);
    write_reg(tpws_pkg::RegTolDiv, 16'd255);
    send_sample(16'sd1000, 16'sd1003, 16'sd1004, 1'b1);
    drain();
    write_reg(tpws_pkg::RegTolDiv, 16'd0);
    send_sample(16'sd2000, 16'sd2001, 16'sd0, 1'b1);
    drain();
    write_reg(tpws_pkg::RegTolDiv, 16'd1);
    write_reg(tpws_pkg::RegNominal, 16'h7FFF);
    send_sample(16'sh7FFF, 16'sh8000, 16'sd100, 1'b1);
    drain();
    write_reg(tpws_pkg::RegNominal, 16'hFFFF);
    write_reg(tpws_pkg::RegTolDiv, 16'hFF03);
    send_random_window(2);
  endtask

  task automatic test_random(int goal);
    int sent;
    sent = 0;
    while (sent < goal) begin
      int len;
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_window(len);
      sent += len;
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        drain();
        write_reg(tpws_pkg::RegClipLimit, 16'($urandom));
        write_reg(tpws_pkg::RegNominal, 16'($urandom_range(0, 40000)));
        write_reg(tpws_pkg::RegTolDiv, 16'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    push        = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    samples_sent = 0;
    windows_sent = 0;
    results_seen = 0;
    stalls_on   = 1'b1;
    clip_level    = 32767;
    nominal_level = 0;
    tol_div       = 10;
    clear_totals();
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_clip_limits();
    test_tolerance();
    test_random(305);
    stalls_on = 1'b0;
    test_random(80);
    drain();

    $display("sent %0d samples in %0d windows, checked %0d results",
             samples_sent, windows_sent, results_seen);
    $display("covered sample extremes, clip limits, tolerance band settings, random windows");
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tpws_pkg.sv
src/tpws_front.sv
src/tpws_queue.sv
src/tpws_div.sv
src/tpws_back.sv
src/three_phase_window_statistics_top.sv
tb/three_phase_window_statistics_top_tb.sv
